// ===== rtl/rag_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes and field widths for the resource allocation graph deadlock detector.
package rag_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 4;
    localparam int CFG_W   = 5;
    localparam int CADDR_W = 1;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_DETECT  = 2'd2;

    localparam logic [CADDR_W-1:0] REG_NUM_PROCESSES = 1'd0;
    localparam logic [CADDR_W-1:0] REG_NUM_RESOURCES = 1'd1;

    localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 5'd16;

endpackage

// ===== rtl/rag_deadlock_cycle_detector.sv =====
`timescale 1ns / 1ps
// Deadlock detector: edge store, iterative depth-first search and result register.
// Edge load items (request or allocation) are taken in idle and leave it idle; the block is ready again next cycle.
// A detect item walks the graph with an explicit stack, testing one adjacency bit per cycle
// in ST_WALK, over N = MAX_PROCESSES + MAX_RESOURCES nodes.
// The result leaves through an output register; edge loads are taken while it waits.
// Reset (aresetn low, synchronous) empties the graph at once through row valid bits; no sweep.
module rag_deadlock_cycle_detector #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: op[1:0], process_id[5:2], resource_id[9:6], zero fill above
    input  logic [rag_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: deadlock[0], bad_edge[1], zero fill above
    output logic [rag_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [rag_pkg::CADDR_W-1:0]    cfg_addr,
    input  logic [rag_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int N  = MAX_PROCESSES + MAX_RESOURCES;
    localparam int NB = $clog2(N);
    localparam int NW = $clog2(N + 1);
    localparam int CW = ($clog2(N + 1) > rag_pkg::CFG_W) ? $clog2(N + 1) : rag_pkg::CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_WALK,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [NB-1:0] node;
        logic [NW-1:0] next;
    } stk_entry_t;

    // input fields
    logic [rag_pkg::OP_W-1:0] in_op;
    logic [rag_pkg::ID_W-1:0] in_pid;
    logic [rag_pkg::ID_W-1:0] in_rid;

    assign in_op  = s_tdata[1:0];
    assign in_pid = s_tdata[5:2];
    assign in_rid = s_tdata[9:6];

    state_t                   state_reg, state_next;
    logic [CW-1:0]            np_eff, nr_eff;
    logic [rag_pkg::CFG_W-1:0] num_proc_reg, num_res_reg;
    logic [N-1:0]             visited_reg, visited_next;
    logic [N-1:0]             on_path_reg, on_path_next;
    logic [N-1:0]             row_valid_reg, row_valid_next;
    logic [NW-1:0]            start_reg, start_next;
    logic [NW-1:0]            depth_reg, depth_next;
    logic [NB-1:0]            top_node_reg, top_node_next;
    logic [NW-1:0]            top_next_reg, top_next_next;
    logic                     dropped_reg, dropped_next;
    logic                     cycle_reg, cycle_next;
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_bits_reg, m_bits_next;

    // adjacency store and search stack
    logic [N-1:0]  adj_mem [N];
    logic [N-1:0]  row_data_reg;
    logic          row_ok_reg;
    stk_entry_t    stk_mem [N];
    stk_entry_t    stk_rd_reg;

    logic          accept;
    logic          wr_en;
    logic [NB-1:0] wr_row, wr_col;
    logic [NB-1:0] rd_addr;
    logic [NB-1:0] stk_rd_addr;
    logic          stk_we;
    logic [NB-1:0] stk_wr_addr;
    stk_entry_t    stk_wr_data;

    logic          p_ok, r_ok;
    logic [NB-1:0] vi;
    logic [NB-1:0] si;
    logic          scan_end;
    logic          edge_hit;

    function automatic logic [CW-1:0] clamp_count(input logic [rag_pkg::CFG_W-1:0] v,
                                                  input int maxv);
        logic [CW-1:0] vw;
        vw = CW'(v);
        if (v == '0) begin
            return CW'(1);
        end else if (vw > CW'(maxv)) begin
            return CW'(maxv);
        end
        return vw;
    endfunction

    function automatic logic node_in_use(input logic [NB-1:0] n,
                                         input logic [CW-1:0] np,
                                         input logic [CW-1:0] nr);
        logic [CW-1:0] nw;
        nw = CW'(n);
        if (nw < CW'(MAX_PROCESSES)) begin
            return nw < np;
        end
        return (nw - CW'(MAX_PROCESSES)) < nr;
    endfunction

    assign np_eff   = clamp_count(num_proc_reg, MAX_PROCESSES);
    assign nr_eff   = clamp_count(num_res_reg, MAX_RESOURCES);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign p_ok     = CW'(in_pid) < np_eff;
    assign r_ok     = CW'(in_rid) < nr_eff;

    assign vi       = top_next_reg[NB-1:0];
    assign si       = start_reg[NB-1:0];
    assign scan_end = (top_next_reg == NW'(N));
    assign edge_hit = row_ok_reg && row_data_reg[vi] && node_in_use(vi, np_eff, nr_eff);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rag_pkg::M_DATA_W-2){1'b0}}, m_bits_reg};

    always_comb begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        on_path_next   = on_path_reg;
        row_valid_next = row_valid_reg;
        start_next     = start_reg;
        depth_next     = depth_reg;
        top_node_next  = top_node_reg;
        top_next_next  = top_next_reg;
        dropped_next   = dropped_reg;
        cycle_next     = cycle_reg;
        m_valid_next   = m_valid_reg;
        m_bits_next    = m_bits_reg;
        wr_en          = 1'b0;
        wr_row         = NB'(in_pid);
        wr_col         = NB'(MAX_PROCESSES) + NB'(in_rid);
        rd_addr        = top_node_reg;
        stk_rd_addr    = NB'(depth_reg - NW'(2));
        stk_we         = 1'b0;
        stk_wr_addr    = NB'(depth_reg - NW'(1));
        stk_wr_data    = '{node: top_node_reg, next: top_next_reg + NW'(1)};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        rag_pkg::OP_REQUEST, rag_pkg::OP_ALLOC: begin
                            if (p_ok && r_ok) begin
                                wr_en = 1'b1;
                                if (in_op == rag_pkg::OP_ALLOC) begin
                                    wr_row = NB'(MAX_PROCESSES) + NB'(in_rid);
                                    wr_col = NB'(in_pid);
                                end
                                row_valid_next[wr_row] = 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        rag_pkg::OP_DETECT: begin
                            visited_next = '0;
                            on_path_next = '0;
                            start_next   = '0;
                            depth_next   = '0;
                            cycle_next   = 1'b0;
                            state_next   = ST_SEL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEL: begin
                // outer loop over start nodes
                rd_addr = si;
                if (start_reg == NW'(N)) begin
                    state_next = ST_FINISH;
                end else if (node_in_use(si, np_eff, nr_eff) && !visited_reg[si]) begin
                    visited_next[si] = 1'b1;
                    on_path_next[si] = 1'b1;
                    top_node_next    = si;
                    top_next_next    = '0;
                    depth_next       = NW'(1);
                    state_next       = ST_WALK;
                end else begin
                    start_next = start_reg + NW'(1);
                end
            end
            ST_WALK: begin
                if (scan_end) begin
                    on_path_next[top_node_reg] = 1'b0;
                    depth_next = depth_reg - NW'(1);
                    if (depth_reg == NW'(1)) begin
                        state_next = ST_SEL;
                    end else begin
                        state_next = ST_POP;
                    end
                end else begin
                    top_next_next = top_next_reg + NW'(1);
                    if (edge_hit) begin
                        if (on_path_reg[vi]) begin
                            cycle_next = 1'b1;
                            state_next = ST_FINISH;
                        end else if (!visited_reg[vi] && depth_reg < NW'(N)) begin
                            // descend: park the current frame, its scan resumes past v
                            stk_we         = 1'b1;
                            visited_next[vi] = 1'b1;
                            on_path_next[vi] = 1'b1;
                            top_node_next  = vi;
                            top_next_next  = '0;
                            depth_next     = depth_reg + NW'(1);
                            rd_addr        = vi;
                        end
                    end
                end
            end
            ST_POP: begin
                // parent frame is back from the stack; fetch its row
                top_node_next = stk_rd_reg.node;
                top_next_next = stk_rd_reg.next;
                rd_addr       = stk_rd_reg.node;
                state_next    = ST_WALK;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_bits_next    = {dropped_reg, cycle_reg};
                    dropped_next   = 1'b0;
                    row_valid_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            visited_reg   <= '0;
            on_path_reg   <= '0;
            row_valid_reg <= '0;
            start_reg     <= '0;
            depth_reg     <= '0;
            dropped_reg   <= 1'b0;
            cycle_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            num_proc_reg  <= rag_pkg::CFG_COUNT_RESET;
            num_res_reg   <= rag_pkg::CFG_COUNT_RESET;
        end else begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            on_path_reg   <= on_path_next;
            row_valid_reg <= row_valid_next;
            start_reg     <= start_next;
            depth_reg     <= depth_next;
            dropped_reg   <= dropped_next;
            cycle_reg     <= cycle_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    rag_pkg::REG_NUM_PROCESSES: num_proc_reg <= cfg_wdata;
                    rag_pkg::REG_NUM_RESOURCES: num_res_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        top_node_reg <= top_node_next;
        top_next_reg <= top_next_next;
        m_bits_reg   <= m_bits_next;
    end

    // adjacency rows; a row not yet valid is written whole
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (row_valid_reg[wr_row]) begin
                adj_mem[wr_row][wr_col] <= 1'b1;
            end else begin
                adj_mem[wr_row] <= N'(1) << wr_col;
            end
        end
        row_data_reg <= adj_mem[rd_addr];
        row_ok_reg   <= row_valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        stk_rd_reg <= stk_mem[stk_rd_addr];
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= NW'(N))
        else $error("search stack depth beyond node count");

    a_path_in_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (on_path_reg & ~visited_reg) == '0)
        else $error("node on path but not visited");

    a_path_matches_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(on_path_reg) == int'(depth_reg))
        else $error("path marks disagree with stack depth");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_busy_while_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == rag_pkg::OP_DETECT) |=> !s_tready)
        else $error("ready while detect in progress");

endmodule
